// ----- design/dhcp_reply_parser_macros.svh -----
// Assertion macros shared by the DHCP reply parser.
// Expects clk and arst_n to be in scope where used.
`ifndef DHCP_REPLY_PARSER_MACROS_SVH
`define DHCP_REPLY_PARSER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DRP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define DRP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/dhcp_pkg.sv -----
// Types and constants for the DHCP reply parser.
// No dependencies; imported by every module of the block.
package dhcp_pkg;

	localparam int unsigned FIFO_DEPTH_DEF = 2;

	localparam logic [7:0]  HDR_LEN       = 8'd240;
	localparam logic [7:0]  HDR_LAST      = 8'd239;
	localparam logic [31:0] MAGIC_COOKIE  = 32'h6382_5363;
	localparam logic [31:0] MASK_RESET    = 32'hFFFF_FF00;
	localparam logic [7:0]  OP_REPLY      = 8'd2;
	localparam logic [7:0]  OPT_PAD       = 8'd0;
	localparam logic [7:0]  OPT_MASK      = 8'd1;
	localparam logic [7:0]  OPT_GATEWAY   = 8'd3;
	localparam logic [7:0]  OPT_DNS       = 8'd6;
	localparam logic [7:0]  OPT_MSG_TYPE  = 8'd53;
	localparam logic [7:0]  OPT_SERVER_ID = 8'd54;
	localparam logic [7:0]  OPT_END       = 8'd255;
	localparam logic [7:0]  TYPE_OFFER    = 8'd2;
	localparam logic [7:0]  TYPE_ACK      = 8'd5;

	localparam logic KIND_BYTE  = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic        accepted;
		logic [7:0]  message_type;
		logic        offer_seen;
		logic        ack_seen;
		logic [31:0] lease_address;
		logic [31:0] lease_mask;
		logic [31:0] lease_gateway;
		logic [31:0] lease_dns;
		logic [31:0] lease_server;
	} out_item_t;

	// Classified byte: the item plus its position in the packet (saturates at HDR_LEN).
	typedef struct packed {
		in_item_t   item;
		logic [7:0] pos;
	} entry_t;

	typedef struct packed {
		logic full;
		logic not_empty;
	} fifo_status_t;

endpackage

// ----- design/dhcp_front.sv -----
// Front end: takes input transfers and tags each byte with its packet position.
// Uses dhcp_pkg; feeds dhcp_fifo.
module dhcp_front import dhcp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  in_item_t     in_data,
	output logic         in_stall,
	input  fifo_status_t fifo_st,
	output logic         push,
	output entry_t       push_data
);

	logic [7:0] pos_q;

	assign in_stall       = fifo_st.full;
	assign push           = in_valid && !fifo_st.full;
	assign push_data.item = in_data;
	assign push_data.pos  = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			if (in_data.kind == KIND_START || in_data.last_byte)
				pos_q <= '0;
			else if (pos_q != HDR_LEN)
				pos_q <= pos_q + 8'd1;
		end
	end

endmodule

// ----- design/dhcp_fifo.sv -----
// Short queue between front end and parser back end.
// Uses dhcp_pkg for the entry and status types.
module dhcp_fifo import dhcp_pkg::*; #(
	parameter int unsigned DEPTH = FIFO_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  entry_t       push_data,
	input  logic         pop,
	output entry_t       pop_data,
	output fifo_status_t status
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t           mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.full      = (count_q == CNT_FULL);
	assign status.not_empty = (count_q != '0);
	assign pop_data         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			if (push && !pop)
				count_q <= count_q + CNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

// ----- design/dhcp_back.sv -----
// Back end: header checks, option walk, lease store and the result register.
// Uses dhcp_pkg; drains dhcp_fifo.
module dhcp_back import dhcp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [31:0]  tid,
	input  fifo_status_t fifo_st,
	input  entry_t       entry,
	output logic         pop,
	output logic         out_valid,
	input  logic         out_stall,
	output out_item_t    out_data
);

	typedef enum logic [1:0] {PH_CODE, PH_LEN, PH_VALUE, PH_DONE} phase_t;

	phase_t      phase_q, phase_n;
	logic        hg_q, hg_n;
	logic [7:0]  code_q, code_n;
	logic [7:0]  rem_q, rem_n;
	logic [7:0]  len_q, len_n;
	logic [31:0] vc_q, vc_n;
	logic [7:0]  ptype_q, ptype_n;
	logic [31:0] shift_q, shift_n;
	logic [31:0] addr_q, addr_n;
	logic [31:0] mask_q, mask_n;
	logic [31:0] gw_q, gw_n;
	logic [31:0] dns_q, dns_n;
	logic [31:0] srv_q, srv_n;
	logic        offer_q, offer_n;
	logic        ack_q, ack_n;
	logic        result;
	logic        acc;
	logic [7:0]  mtype;
	logic [7:0]  b;
	logic [7:0]  pos;
	out_item_t   out_q;
	out_item_t   res_data;
	logic        out_valid_q;

	assign pop       = fifo_st.not_empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign b         = entry.item.data_byte;
	assign pos       = entry.pos;

	always_comb begin
		phase_n = phase_q;
		hg_n    = hg_q;
		code_n  = code_q;
		rem_n   = rem_q;
		len_n   = len_q;
		vc_n    = vc_q;
		ptype_n = ptype_q;
		shift_n = shift_q;
		addr_n  = addr_q;
		mask_n  = mask_q;
		gw_n    = gw_q;
		dns_n   = dns_q;
		srv_n   = srv_q;
		offer_n = offer_q;
		ack_n   = ack_q;
		result  = 1'b0;
		acc     = 1'b0;
		mtype   = '0;

		if (entry.item.kind == KIND_BYTE && pos < HDR_LEN) begin
			if (pos == 8'd0 && b != OP_REPLY)
				hg_n = 1'b0;
			if (pos inside {[8'd4:8'd7], [8'd236:8'd239]})
				shift_n = {shift_q[23:0], b};
			if (pos == 8'd7 && shift_n != tid)
				hg_n = 1'b0;
			if (pos inside {[8'd16:8'd19]})
				vc_n = {vc_q[23:0], b};
			if (pos == HDR_LAST) begin
				if (shift_n != MAGIC_COOKIE)
					hg_n = 1'b0;
				if (hg_n)
					addr_n = vc_q;
			end
		end else if (entry.item.kind == KIND_BYTE && hg_q) begin
			case (phase_q)
				PH_CODE: begin
					if (b == OPT_END) begin
						phase_n = PH_DONE;
					end else if (b != OPT_PAD) begin
						code_n  = b;
						phase_n = PH_LEN;
					end
				end
				PH_LEN: begin
					len_n   = b;
					rem_n   = b;
					vc_n    = '0;
					phase_n = (b == 8'd0) ? PH_CODE : PH_VALUE;
				end
				PH_VALUE: begin
					if ((len_q - rem_q) < 8'd4)
						vc_n = {vc_q[23:0], b};
					rem_n = rem_q - 8'd1;
					if (rem_n == 8'd0) begin
						phase_n = PH_CODE;
						if (code_q == OPT_MSG_TYPE) begin
							if (len_q >= 8'd4) begin
								ptype_n = vc_n[31:24];
							end else begin
								case (len_q[1:0])
									2'd1:    ptype_n = vc_n[7:0];
									2'd2:    ptype_n = vc_n[15:8];
									2'd3:    ptype_n = vc_n[23:16];
									default: ptype_n = ptype_q;
								endcase
							end
						end else if (len_q >= 8'd4) begin
							case (code_q)
								OPT_MASK:      mask_n = vc_n;
								OPT_GATEWAY:   gw_n   = vc_n;
								OPT_DNS:       dns_n  = vc_n;
								OPT_SERVER_ID: srv_n  = vc_n;
								default:       ;
							endcase
						end
					end
				end
				default: ;
			endcase
		end

		if (entry.item.kind == KIND_BYTE && entry.item.last_byte) begin
			result = 1'b1;
			acc    = hg_n && (pos >= HDR_LAST);
			mtype  = acc ? ptype_n : 8'd0;
			if (acc && mtype == TYPE_OFFER)
				offer_n = 1'b1;
			else if (acc && mtype == TYPE_ACK)
				ack_n = 1'b1;
		end

		if (entry.item.kind == KIND_START) begin
			offer_n = 1'b0;
			ack_n   = 1'b0;
		end

		res_data.accepted      = acc;
		res_data.message_type  = mtype;
		res_data.offer_seen    = offer_n;
		res_data.ack_seen      = ack_n;
		res_data.lease_address = addr_n;
		res_data.lease_mask    = mask_n;
		res_data.lease_gateway = gw_n;
		res_data.lease_dns     = dns_n;
		res_data.lease_server  = srv_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_CODE;
			hg_q        <= 1'b1;
			code_q      <= '0;
			rem_q       <= '0;
			len_q       <= '0;
			vc_q        <= '0;
			ptype_q     <= '0;
			shift_q     <= '0;
			addr_q      <= '0;
			mask_q      <= MASK_RESET;
			gw_q        <= '0;
			dns_q       <= '0;
			srv_q       <= '0;
			offer_q     <= 1'b0;
			ack_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (pop) begin
				addr_q  <= addr_n;
				mask_q  <= mask_n;
				gw_q    <= gw_n;
				dns_q   <= dns_n;
				srv_q   <= srv_n;
				offer_q <= offer_n;
				ack_q   <= ack_n;
				if (entry.item.kind == KIND_START || entry.item.last_byte) begin
					// packet restart
					phase_q <= PH_CODE;
					hg_q    <= 1'b1;
					code_q  <= '0;
					rem_q   <= '0;
					len_q   <= '0;
					vc_q    <= '0;
					ptype_q <= '0;
					shift_q <= '0;
				end else begin
					phase_q <= phase_n;
					hg_q    <= hg_n;
					code_q  <= code_n;
					rem_q   <= rem_n;
					len_q   <= len_n;
					vc_q    <= vc_n;
					ptype_q <= ptype_n;
					shift_q <= shift_n;
				end
				if (result) begin
					out_valid_q <= 1'b1;
					out_q       <= res_data;
				end
			end
		end
	end

endmodule

// ----- design/dhcp_reply_parser.sv -----
// DHCP reply parser top level. Uses dhcp_pkg, dhcp_front, dhcp_fifo, dhcp_back.
// Throughput: one item per cycle; the parser back end handles one byte a cycle
// while the output is not stalled. After its last byte is transferred, a result
// passes the queue, then the result register, and is held up by a stalled output.
// Reset: asynchronous, active low; clears queue, parser state, flags, lease store;
// the lease mask resets to MASK_RESET. No clearing pass is needed after reset.
`include "dhcp_reply_parser_macros.svh"
module dhcp_reply_parser import dhcp_pkg::*; #(
	parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [31:0]  tid_q;
	fifo_status_t fifo_st;
	logic         push;
	logic         pop;
	entry_t       push_data;
	entry_t       pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tid_q <= '0;
		else if (cfg_we)
			tid_q <= cfg_wdata;
	end

	dhcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.in_stall  (in_stall),
		.fifo_st   (fifo_st),
		.push      (push),
		.push_data (push_data)
	);

	dhcp_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_st)
	);

	dhcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tid       (tid_q),
		.fifo_st   (fifo_st),
		.entry     (pop_data),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`DRP_ASSERT_NOW(a_reject_no_type, out_valid && !out_data.accepted, out_data.message_type == 8'd0, "rejected packet reports a message type")
	`DRP_ASSERT_NOW(a_offer_sticky, out_valid && out_data.accepted && out_data.message_type == TYPE_OFFER, out_data.offer_seen, "offer not flagged")
	`DRP_ASSERT_NOW(a_ack_sticky, out_valid && out_data.accepted && out_data.message_type == TYPE_ACK, out_data.ack_seen, "ack not flagged")
	`DRP_ASSERT_NEXT(a_pop_needs_data, !fifo_st.not_empty && !push, !pop, "pop from empty queue")

endmodule
